@@ rtl/gst_pkg.sv @@
package gst_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 24;
    localparam int ACC_WIDTH   = 48;

    localparam int NUM_AXES = 3;
    localparam int AXIS_W   = 2;
    localparam int REQ_W    = 2;

    // floor(acc * value / 2^frac) always fits here
    localparam int PROD_WIDTH = ACC_WIDTH + VALUE_WIDTH - FRAC_BITS;
    localparam int SUM_WIDTH  = ((PROD_WIDTH > ACC_WIDTH) ? PROD_WIDTH : ACC_WIDTH) + 1;

    localparam logic [REQ_W-1:0] REQ_TERM   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_METRIC = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FINISH = 2'd2;

    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

    typedef logic signed [VALUE_WIDTH-1:0] val_t;
    typedef logic signed [ACC_WIDTH-1:0]   acc_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_MERGE
    } state_t;

    typedef struct packed {
        logic              valid;
        logic              is_term;
        logic              first;
        logic              last;
        logic              clear;
        logic [AXIS_W-1:0] row;
        logic [AXIS_W-1:0] col;
    } lane_ctl_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][ACC_WIDTH-1:0] grad;
        logic                               sat;
    } lane_res_t;

endpackage

@@ rtl/gst_item_if.sv @@
interface gst_item_if;
    import gst_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic [AXIS_W-1:0]       axis;
    logic signed [VALUE_WIDTH-1:0] coef;
    logic signed [VALUE_WIDTH-1:0] val_a;
    logic signed [VALUE_WIDTH-1:0] val_b;
    logic signed [VALUE_WIDTH-1:0] val_c;

    modport source (
        output valid, req_type, axis, coef, val_a, val_b, val_c,
        input  ready
    );

    modport sink (
        input  valid, req_type, axis, coef, val_a, val_b, val_c,
        output ready
    );
endinterface

@@ rtl/gst_strain_if.sv @@
interface gst_strain_if;
    import gst_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] strain_xx;
    logic signed [VALUE_WIDTH-1:0] strain_yy;
    logic signed [VALUE_WIDTH-1:0] strain_zz;
    logic signed [VALUE_WIDTH-1:0] strain_xy;
    logic signed [VALUE_WIDTH-1:0] strain_xz;
    logic signed [VALUE_WIDTH-1:0] strain_yz;
    logic                          saturated;

    modport source (
        output valid, strain_xx, strain_yy, strain_zz, strain_xy, strain_xz, strain_yz,
               saturated,
        input  ready
    );

    modport sink (
        input  valid, strain_xx, strain_yy, strain_zz, strain_xy, strain_xz, strain_yz,
               saturated,
        output ready
    );
endinterface

@@ rtl/gll_node_strain_tensor_core.sv @@
// channel | dir | beat contents
// --------+-----+-----------------------------------------------------------
// item    | in  | req_type, axis, coef, val_a, val_b, val_c
// strain  | out | strain_xx/yy/zz/xy/xz/yz (Q8.24), saturated; finish only
//
// one item at a time: item.ready is high only in idle; a metric load stays in idle, a
// term issues and drains, and a finish also waits in merge for the output register
// the term and finish loops run on three lanes (one per displacement component),
// each a 3-stage split multiply and saturating accumulate; a finish walks 9 steps
// the output register holds one result, so items keep flowing while it waits
// rst_n clears control and accumulators; the metric is undefined until loaded
module gll_node_strain_tensor_core (
    input  logic         clk,
    input  logic         rst_n,
    gst_item_if.sink     item,
    gst_strain_if.source strain
);
    import gst_pkg::*;

    state_t            state_reg, state_next;
    logic              fin_reg, fin_next;
    logic              drain_reg, drain_next;
    logic [AXIS_W-1:0] row_reg, row_next;
    logic [AXIS_W-1:0] col_reg, col_next;

    val_t coef_reg;
    val_t val_reg [NUM_AXES];
    val_t metric_reg [NUM_AXES][NUM_AXES];
    val_t item_val [NUM_AXES];

    logic      accept;
    logic      axis_ok;
    logic      metric_we;
    logic      merge_load;
    logic      merge_free;
    lane_ctl_t issue;
    val_t      metric_rd;
    lane_res_t [NUM_AXES-1:0] lane_res;

    assign item.ready  = (state_reg == ST_IDLE);
    assign accept      = item.valid && item.ready;
    assign axis_ok     = (item.axis <= LAST_AXIS);
    assign metric_we   = accept && axis_ok && (item.req_type == REQ_METRIC);
    assign item_val[0] = item.val_a;
    assign item_val[1] = item.val_b;
    assign item_val[2] = item.val_c;

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        drain_next = drain_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        merge_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && axis_ok && item.req_type == REQ_TERM)
                begin
                    fin_next   = 1'b0;
                    row_next   = item.axis;
                    state_next = ST_ISSUE;
                end
                else if (accept && item.req_type == REQ_FINISH)
                begin
                    fin_next   = 1'b1;
                    row_next   = '0;
                    col_next   = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (!fin_reg)
                begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
                else if (row_reg == LAST_AXIS)
                begin
                    row_next = '0;
                    if (col_reg == LAST_AXIS)
                    begin
                        drain_next = 1'b0;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // stay here until the last accumulate has passed s1_reg and s2_reg and landed
                if (drain_reg)
                begin
                    state_next = fin_reg ? ST_MERGE : ST_IDLE;
                end
                else
                begin
                    drain_next = 1'b1;
                end
            end
            ST_MERGE:
            begin
                merge_load = merge_free;
                if (merge_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        issue.valid   = (state_reg == ST_ISSUE);
        issue.is_term = !fin_reg;
        issue.first   = (row_reg == '0);
        issue.last    = (row_reg == LAST_AXIS);
        issue.clear   = fin_reg && (row_reg == LAST_AXIS) && (col_reg == LAST_AXIS);
        issue.row     = row_reg;
        issue.col     = col_reg;
        metric_rd     = metric_reg[col_reg][row_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
            drain_reg <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            drain_reg <= drain_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coef_reg <= item.coef;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                val_reg[i] <= item_val[i];
            end
        end
        if (metric_we)
        begin
            for (int r = 0; r < NUM_AXES; r++)
            begin
                metric_reg[item.axis][r] <= item_val[r];
            end
        end
    end

    for (genvar d = 0; d < NUM_AXES; d++)
    begin : g_lane
        gst_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (issue),
            .coef   (coef_reg),
            .val    (val_reg[d]),
            .metric (metric_rd),
            .res    (lane_res[d])
        );
    end

    gst_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (merge_load),
        .lanes  (lane_res),
        .free   (merge_free),
        .strain (strain)
    );

    a_finish_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.req_type == REQ_FINISH
        |=> state_reg == ST_ISSUE && fin_reg && row_reg == '0 && col_reg == '0)
        else $error("finish did not start its sweep at the first step");

    a_term_length: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ISSUE && !fin_reg
        |=> state_reg == ST_DRAIN ##2 state_reg == ST_IDLE)
        else $error("derivative term took the wrong number of cycles");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(strain.valid) |-> $past(state_reg) == ST_MERGE)
        else $error("result appeared outside the merge step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MERGE && strain.valid && !strain.ready
        |=> strain.valid && state_reg == ST_MERGE)
        else $error("pending result overwritten or merge step skipped");

endmodule

@@ rtl/gst_lane.sv @@
module gst_lane (
    input  logic              clk,
    input  logic              rst_n,
    input  gst_pkg::lane_ctl_t ctl,
    input  gst_pkg::val_t     coef,
    input  gst_pkg::val_t     val,
    input  gst_pkg::val_t     metric,
    output gst_pkg::lane_res_t res
);
    import gst_pkg::*;

    localparam int HI_W = ACC_WIDTH - FRAC_BITS;
    localparam int LO_W = FRAC_BITS + 1;
    localparam int HP_W = HI_W + VALUE_WIDTH;
    localparam int LP_W = LO_W + VALUE_WIDTH;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    acc_t acc_reg [NUM_AXES];
    acc_t grad_reg [NUM_AXES];
    acc_t s_reg;
    logic sat_reg;

    lane_ctl_t s1_reg;
    lane_ctl_t s2_reg;

    acc_t                     op_a;
    val_t                     op_b;
    logic signed [HI_W-1:0]   a_hi;
    logic signed [LO_W-1:0]   a_lo;
    logic signed [HP_W-1:0]   hi_p_next;
    logic signed [HP_W-1:0]   hi_p_reg;
    logic signed [LP_W-1:0]   lo_p_next;
    logic signed [LP_W-1:0]   lo_p_reg;
    logic signed [VALUE_WIDTH:0] lo_sh;
    logic signed [PROD_WIDTH-1:0] prod_next;
    logic signed [PROD_WIDTH-1:0] prod_reg;
    acc_t                     base;
    logic signed [SUM_WIDTH-1:0] sum;
    logic                     clip;
    acc_t                     sat_val;

    // operand a split at the binary point: a = hi * 2^frac + lo, lo unsigned
    always_comb
    begin
        op_a      = ctl.is_term ? ACC_WIDTH'(coef) : acc_reg[ctl.row];
        op_b      = ctl.is_term ? val : metric;
        a_hi      = op_a[ACC_WIDTH-1:FRAC_BITS];
        a_lo      = $signed({1'b0, op_a[FRAC_BITS-1:0]});
        hi_p_next = HP_W'(a_hi) * HP_W'(op_b);
        lo_p_next = LP_W'(a_lo) * LP_W'(op_b);
    end

    // hi part has no fraction bits, so the floor only touches the lo part
    always_comb
    begin
        lo_sh     = lo_p_reg[LP_W-1:FRAC_BITS];
        prod_next = hi_p_reg + PROD_WIDTH'(lo_sh);
    end

    always_comb
    begin
        if (s2_reg.is_term)
        begin
            base = acc_reg[s2_reg.row];
        end
        else
        begin
            base = s2_reg.first ? '0 : s_reg;
        end
        sum  = SUM_WIDTH'(base) + SUM_WIDTH'(prod_reg);
        clip = sum[SUM_WIDTH-1:ACC_WIDTH-1] != {(SUM_WIDTH-ACC_WIDTH+1){sum[SUM_WIDTH-1]}};
        if (clip)
        begin
            sat_val = sum[SUM_WIDTH-1] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            sat_val = sum[ACC_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            s1_reg <= ctl;
            s2_reg <= s1_reg;
            if (s2_reg.valid)
            begin
                if (s2_reg.is_term)
                begin
                    acc_reg[s2_reg.row] <= sat_val;
                end
                else if (s2_reg.clear)
                begin
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        acc_reg[i] <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hi_p_reg <= hi_p_next;
        lo_p_reg <= lo_p_next;
        prod_reg <= prod_next;
        if (s2_reg.valid && !s2_reg.is_term)
        begin
            s_reg <= sat_val;
            if (s2_reg.last)
            begin
                grad_reg[s2_reg.col] <= sat_val;
            end
            // sticky over the whole finish, restarted at its first product
            if (s2_reg.first && s2_reg.col == '0)
            begin
                sat_reg <= clip;
            end
            else
            begin
                sat_reg <= sat_reg | clip;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            res.grad[i] = grad_reg[i];
        end
        res.sat = sat_reg;
    end

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s2_reg.valid && !s2_reg.is_term && s2_reg.clear
        |=> acc_reg[0] == '0 && acc_reg[1] == '0 && acc_reg[2] == '0)
        else $error("accumulators not cleared after finish");

    a_term_keeps_grad: assert property (@(posedge clk) disable iff (!rst_n)
        s2_reg.valid && s2_reg.is_term |=> $stable(res.grad))
        else $error("derivative term disturbed gradient results");

endmodule

@@ rtl/gst_merge.sv @@
module gst_merge (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      load,
    input  gst_pkg::lane_res_t [gst_pkg::NUM_AXES-1:0] lanes,
    output logic                                      free,
    gst_strain_if.source                              strain
);
    import gst_pkg::*;

    localparam val_t OUT_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam val_t OUT_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // returns {clip, value}
    function automatic logic [VALUE_WIDTH:0] sat_out(input acc_t x);
        logic ovf;
        ovf = x[ACC_WIDTH-1:VALUE_WIDTH-1] != {(ACC_WIDTH-VALUE_WIDTH+1){x[ACC_WIDTH-1]}};
        if (ovf)
        begin
            return {1'b1, (x[ACC_WIDTH-1] ? OUT_MIN : OUT_MAX)};
        end
        return {1'b0, x[VALUE_WIDTH-1:0]};
    endfunction

    // floor((a + b) / 2)
    function automatic acc_t half_sum(input acc_t a, input acc_t b);
        logic signed [ACC_WIDTH:0] s;
        s = (ACC_WIDTH+1)'(a) + (ACC_WIDTH+1)'(b);
        return s[ACC_WIDTH:1];
    endfunction

    logic                 valid_reg;
    logic                 valid_next;
    val_t                 xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic                 sat_reg;
    logic [VALUE_WIDTH:0] xx_s, yy_s, zz_s, xy_s, xz_s, yz_s;
    logic                 sat_any;

    // lanes[d].grad[c] holds du_d / dx_c
    always_comb
    begin
        xx_s = sat_out(lanes[0].grad[0]);
        yy_s = sat_out(lanes[1].grad[1]);
        zz_s = sat_out(lanes[2].grad[2]);
        xy_s = sat_out(half_sum(lanes[0].grad[1], lanes[1].grad[0]));
        xz_s = sat_out(half_sum(lanes[0].grad[2], lanes[2].grad[0]));
        yz_s = sat_out(half_sum(lanes[1].grad[2], lanes[2].grad[1]));
        sat_any = lanes[0].sat | lanes[1].sat | lanes[2].sat
                | xx_s[VALUE_WIDTH] | yy_s[VALUE_WIDTH] | zz_s[VALUE_WIDTH]
                | xy_s[VALUE_WIDTH] | xz_s[VALUE_WIDTH] | yz_s[VALUE_WIDTH];
    end

    assign free = !valid_reg || strain.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (strain.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            xx_reg  <= xx_s[VALUE_WIDTH-1:0];
            yy_reg  <= yy_s[VALUE_WIDTH-1:0];
            zz_reg  <= zz_s[VALUE_WIDTH-1:0];
            xy_reg  <= xy_s[VALUE_WIDTH-1:0];
            xz_reg  <= xz_s[VALUE_WIDTH-1:0];
            yz_reg  <= yz_s[VALUE_WIDTH-1:0];
            sat_reg <= sat_any;
        end
    end

    assign strain.valid     = valid_reg;
    assign strain.strain_xx = xx_reg;
    assign strain.strain_yy = yy_reg;
    assign strain.strain_zz = zz_reg;
    assign strain.strain_xy = xy_reg;
    assign strain.strain_xz = xz_reg;
    assign strain.strain_yz = yz_reg;
    assign strain.saturated = sat_reg;

endmodule
